@@ src/bsfr_pkg.sv @@
// Shared types and constants for the byte-stuffed frame receiver.
// No dependencies.
package bsfr_pkg;

    localparam int BYTE_W          = 8;
    localparam int CFG_W           = 9;
    localparam int LEN_W           = 9;
    localparam int MAX_PAYLOAD_DEF = 256;
    localparam int CFG_RESET       = 256;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'h7D;
    localparam logic [BYTE_W-1:0] BYTE_START = 8'h7E;
    localparam logic [BYTE_W-1:0] BYTE_END   = 8'h7F;
    localparam logic [BYTE_W-1:0] ESC_XOR    = 8'h20;

    typedef enum logic [1:0] {
        CLS_DATA,
        CLS_ESC,
        CLS_START,
        CLS_END
    } byte_class_t;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_END,
        KIND_RESTART,
        KIND_OVF
    } kind_t;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_FRAME,
        ST_ESC
    } rx_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        byte_class_t       cls;
    } q_item_t;

    typedef struct packed {
        logic    valid;
        q_item_t item;
    } q_head_t;

endpackage

@@ src/bsfr_front.sv @@
// Front end: accepts line bytes and tags each with its control class.
// Depends on bsfr_pkg.
module bsfr_front (
    input  logic                      in_valid,
    input  logic                      q_full,
    input  logic [bsfr_pkg::BYTE_W-1:0] rx_byte,
    output logic                      in_stall,
    output logic                      push,
    output bsfr_pkg::q_item_t         push_item
);
    import bsfr_pkg::*;

    byte_class_t cls;

    always_comb
    begin
        priority if (rx_byte == BYTE_START)
            cls = CLS_START;
        else if (rx_byte == BYTE_ESC)
            cls = CLS_ESC;
        else if (rx_byte == BYTE_END)
            cls = CLS_END;
        else
            cls = CLS_DATA;
    end

    assign in_stall       = q_full;
    assign push           = in_valid && !q_full;
    assign push_item.data = rx_byte;
    assign push_item.cls  = cls;

endmodule

@@ src/bsfr_queue.sv @@
// Short FIFO between the classifier and the frame state machine.
// Depends on bsfr_pkg.
module bsfr_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bsfr_pkg::q_item_t push_item,
    input  logic              pop,
    output logic              full,
    output bsfr_pkg::q_head_t head
);
    import bsfr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_item_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_pop;

    assign do_pop = pop && (cnt_reg != '0);
    assign full   = (cnt_reg == CNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    assign head.valid = (cnt_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count lost a push");
`endif

endmodule

@@ src/bsfr_back.sv @@
// Back end: frame state machine, payload counter and output register.
// Depends on bsfr_pkg; fed by bsfr_queue.
module bsfr_back #(
    parameter int MAX_PAYLOAD = bsfr_pkg::MAX_PAYLOAD_DEF,
    parameter int CNT_W       = $clog2(MAX_PAYLOAD + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bsfr_pkg::q_head_t             head,
    input  logic [CNT_W-1:0]              limit,
    input  logic                          out_stall,
    output logic                          pop,
    output logic                          out_valid,
    output logic [1:0]                    kind,
    output logic [bsfr_pkg::BYTE_W-1:0]   payload_byte,
    output logic [bsfr_pkg::LEN_W-1:0]    frame_length
);
    import bsfr_pkg::*;

    localparam int WIDE_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    rx_state_t          state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    kind_t              kind_reg, kind_next;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic [LEN_W-1:0]   len_reg, len_next;

    logic               res_valid;
    kind_t              res_kind;
    logic [BYTE_W-1:0]  res_byte;
    logic [LEN_W-1:0]   res_len;
    logic [BYTE_W-1:0]  dec_byte;
    logic               at_limit;
    logic               is_payload;
    logic [WIDE_W-1:0]  count_wide;

    assign pop        = head.valid && (!out_valid_reg || !out_stall);
    assign dec_byte   = (state_reg == ST_ESC) ? (head.item.data ^ ESC_XOR) : head.item.data;
    assign at_limit   = (count_reg >= limit);
    assign count_wide = WIDE_W'(count_reg);
    assign is_payload = (state_reg == ST_ESC) ||
                        (state_reg == ST_FRAME && head.item.cls == CLS_DATA);

    always_comb
    begin
        state_next = state_reg;
        if (pop)
        begin
            unique case (state_reg)
                ST_HUNT:
                    if (head.item.cls == CLS_START)
                        state_next = ST_FRAME;
                ST_FRAME:
                    unique case (head.item.cls)
                        CLS_START: state_next = ST_FRAME;
                        CLS_ESC:   state_next = ST_ESC;
                        CLS_END:   state_next = ST_HUNT;
                        CLS_DATA:  state_next = at_limit ? ST_HUNT : ST_FRAME;
                        default:   state_next = ST_FRAME;
                    endcase
                ST_ESC:
                    state_next = at_limit ? ST_HUNT : ST_FRAME;
                default:
                    state_next = ST_HUNT;
            endcase
        end
    end

    always_comb
    begin
        res_valid  = 1'b0;
        res_kind   = KIND_DATA;
        res_byte   = '0;
        res_len    = '0;
        count_next = count_reg;
        if (pop)
        begin
            if (is_payload)
            begin
                res_valid = 1'b1;
                if (at_limit)
                begin
                    res_kind   = KIND_OVF;
                    count_next = '0;
                end
                else
                begin
                    res_byte   = dec_byte;
                    count_next = count_reg + 1'b1;
                end
            end
            else if (state_reg == ST_HUNT)
                count_next = '0;
            else if (head.item.cls == CLS_START)
            begin
                res_valid  = 1'b1;
                res_kind   = KIND_RESTART;
                count_next = '0;
            end
            else if (head.item.cls == CLS_END)
            begin
                res_valid  = 1'b1;
                res_kind   = KIND_END;
                res_len    = count_wide[LEN_W-1:0];
                count_next = '0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        len_next       = len_reg;
        if (pop)
        begin
            out_valid_next = res_valid;
            kind_next      = res_kind;
            byte_next      = res_byte;
            len_next       = res_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HUNT;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        len_reg  <= len_next;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign payload_byte = byte_reg;
    assign frame_length = len_reg;

`ifndef SYNTHESIS
    a_hunt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && state_reg == ST_HUNT) |-> !res_valid)
        else $error("result while hunting");
    a_hunt_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HUNT |-> count_reg == '0)
        else $error("nonzero count while hunting");
    a_ovf_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && res_valid && res_kind == KIND_OVF) |=> state_reg == ST_HUNT)
        else $error("overflow did not return to hunting");
    a_end_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && res_valid && res_kind == KIND_END) |=> state_reg == ST_HUNT)
        else $error("frame end did not return to hunting");
`endif

endmodule

@@ src/byte_stuffed_frame_receiver.sv @@
// Top level of the byte-stuffed frame receiver.
// Depends on bsfr_pkg, bsfr_front, bsfr_queue and bsfr_back.
//
// Usage:
//   Input channel (in_valid/in_stall/rx_byte) takes one raw line byte per
//   transaction. Bytes before a 0x7E start byte are dropped; 0x7D escapes the
//   next byte (XOR 0x20); 0x7F ends the frame.
//   Output channel (out_valid/out_stall) carries kind, payload_byte and
//   frame_length: payload byte, frame end with length, restart discard or
//   overflow discard. Many bytes give no result transaction.
//   cfg_wr_en/cfg_wr_data write max_payload_len (clamped to 1..MAX_PAYLOAD);
//   write only while the block is idle.
//   Throughput: one byte per cycle unless a stalled result holds the output
//   register; the back end updates the frame state as it pops each byte. An
//   accepted byte is registered in the queue, waits at the queue head and then
//   moves into the output register, where its result is offered.
//   When out_stall is held, the output register holds its transaction, the
//   queue fills, and in_stall rises once it holds two bytes.
//   Reset: hunting for a start byte, queue and output empty, limit 256.
module byte_stuffed_frame_receiver #(
    parameter int MAX_PAYLOAD = bsfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bsfr_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bsfr_pkg::BYTE_W-1:0]   rx_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    kind,
    output logic [bsfr_pkg::BYTE_W-1:0]   payload_byte,
    output logic [bsfr_pkg::LEN_W-1:0]    frame_length
);
    import bsfr_pkg::*;

    localparam int CNT_W   = $clog2(MAX_PAYLOAD + 1);
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int LIM_RST = (CFG_RESET > MAX_PAYLOAD) ? MAX_PAYLOAD : CFG_RESET;

    logic [CNT_W-1:0]  limit_reg, limit_next;
    logic [CMP_W-1:0]  cfg_wide;
    logic [CMP_W-1:0]  cfg_clamped;
    logic              q_full;
    logic              push;
    q_item_t           push_item;
    q_head_t           head;
    logic              pop;

    assign cfg_wide = CMP_W'(cfg_wr_data);

    always_comb
    begin
        priority if (cfg_wide == '0)
            cfg_clamped = CMP_W'(1);
        else if (cfg_wide > CMP_W'(MAX_PAYLOAD))
            cfg_clamped = CMP_W'(MAX_PAYLOAD);
        else
            cfg_clamped = cfg_wide;
        limit_next = cfg_wr_en ? cfg_clamped[CNT_W-1:0] : limit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= CNT_W'(LIM_RST);
        else
            limit_reg <= limit_next;
    end

    bsfr_front u_front (
        .in_valid  (in_valid),
        .q_full    (q_full),
        .rx_byte   (rx_byte),
        .in_stall  (in_stall),
        .push      (push),
        .push_item (push_item)
    );

    bsfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .head      (head)
    );

    bsfr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .CNT_W       (CNT_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .limit        (limit_reg),
        .out_stall    (out_stall),
        .pop          (pop),
        .out_valid    (out_valid),
        .kind         (kind),
        .payload_byte (payload_byte),
        .frame_length (frame_length)
    );

endmodule

@@ dv/bsfr_checker.sv @@
// Checker for the byte-stuffed frame receiver: watches the config port and both channels,
// predicts the result transactions and compares them in order.
// Depends on bsfr_pkg.
module bsfr_checker #(
    parameter int MAX_PAYLOAD = bsfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [bsfr_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [bsfr_pkg::BYTE_W-1:0] rx_byte,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [1:0]                  kind,
    input  logic [bsfr_pkg::BYTE_W-1:0] payload_byte,
    input  logic [bsfr_pkg::LEN_W-1:0]  frame_length,
    output int                          errors,
    output int                          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import bsfr_pkg::*;

    typedef struct {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
    } rx_result_t;

    rx_result_t        expected_q[$];
    logic [CFG_W-1:0]  max_len;
    bit                in_frame;
    bit                esc_pend;
    int unsigned       byte_cnt;
    int                err_cnt;

    function automatic int unsigned frame_limit(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_PAYLOAD)
            return MAX_PAYLOAD;
        return v;
    endfunction

    // Advances the frame state by one line byte; returns 1 when a result is due.
    function automatic bit deframe(input logic [BYTE_W-1:0] b, output rx_result_t r);
        logic [BYTE_W-1:0] d;
        r = '{kind: KIND_DATA, data: '0, len: '0};
        if (!in_frame)
        begin
            if (b == BYTE_START)
            begin
                in_frame = 1'b1;
                esc_pend = 1'b0;
                byte_cnt = 0;
            end
            return 1'b0;
        end
        if (esc_pend)
        begin
            esc_pend = 1'b0;
            d = b ^ ESC_XOR;
        end
        else if (b == BYTE_START)
        begin
            byte_cnt = 0;
            r.kind = KIND_RESTART;
            return 1'b1;
        end
        else if (b == BYTE_ESC)
        begin
            esc_pend = 1'b1;
            return 1'b0;
        end
        else if (b == BYTE_END)
        begin
            r.kind = KIND_END;
            r.len = LEN_W'(byte_cnt);
            in_frame = 1'b0;
            byte_cnt = 0;
            return 1'b1;
        end
        else
            d = b;
        if (byte_cnt >= frame_limit(max_len))
        begin
            in_frame = 1'b0;
            esc_pend = 1'b0;
            byte_cnt = 0;
            r.kind = KIND_OVF;
            return 1'b1;
        end
        byte_cnt++;
        r.data = d;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rx_result_t got;
        rx_result_t want;
        if (!rst_n)
        begin
            expected_q.delete();
            max_len  = CFG_W'(CFG_RESET);
            in_frame = 1'b0;
            esc_pend = 1'b0;
            byte_cnt = 0;
            err_cnt  = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            // output side first: a result never belongs to a byte taken on the same edge
            if (out_valid && !out_stall)
            begin
                got = '{kind: kind_t'(kind), data: payload_byte, len: frame_length};
                if (expected_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected transaction, expected none, %s %0d %0h %0d",
                             $time, "actual kind/data/length", got.kind, got.data,
                             got.len);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.kind !== want.kind)
                    begin
                        err_cnt++;
                        $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
                    end
                    if (got.data !== want.data)
                    begin
                        err_cnt++;
                        $display("%0t: payload_byte expected %0h actual %0h",
                                 $time, want.data, got.data);
                    end
                    if (got.len !== want.len)
                    begin
                        err_cnt++;
                        $display("%0t: frame_length expected %0d actual %0d",
                                 $time, want.len, got.len);
                    end
                end
            end
            if (cfg_wr_en)
                max_len = cfg_wr_data;
            if (in_valid && !in_stall)
            begin
                if (deframe(rx_byte, want))
                    expected_q.push_back(want);
            end
            errors  <= err_cnt;
            pending <= expected_q.size();
        end
    end

endmodule

@@ dv/testbench.sv @@
// Top of the byte-stuffed frame receiver bench: clock, reset, line byte stimulus, receiver
// stalls and the verdict. Depends on bsfr_pkg, byte_stuffed_frame_receiver and bsfr_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bsfr_pkg::*;

    localparam int MAXP         = MAX_PAYLOAD_DEF;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_BYTES  = 25;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]  cfg_wr_data = '0;
    logic              in_valid    = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] rx_byte     = '0;
    logic              out_valid;
    logic              out_stall   = 1'b0;
    logic [1:0]        kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [LEN_W-1:0]  frame_length;
    logic              hold_req    = 1'b0;

    int errors;
    int pending;
    int bytes_sent = 0;
    int burst_left = 0;
    int eff_limit  = CFG_RESET;

    always #6 clk = ~clk;

    byte_stuffed_frame_receiver #(.MAX_PAYLOAD(MAXP)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .payload_byte (payload_byte),
        .frame_length (frame_length)
    );

    bsfr_checker #(.MAX_PAYLOAD(MAXP)) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .payload_byte (payload_byte),
        .frame_length (frame_length),
        .errors       (errors),
        .pending      (pending)
    );

    // Offers one line byte until an edge takes it; after each burst it may idle for a random gap.
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        int gap;
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic push_payload(input logic [BYTE_W-1:0] b);
        if (b == BYTE_ESC || b == BYTE_START || b == BYTE_END)
        begin
            push_byte(BYTE_ESC);
            push_byte(b ^ ESC_XOR);
        end
        else
            push_byte(b);
    endtask

    task automatic send_frame();
        int n;
        int sel;
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) push_byte(BYTE_W'($urandom_range(0, 255)));
        push_byte(BYTE_START);
        n = $urandom_range(0, (eff_limit <= 10) ? eff_limit + 2 : 12);
        repeat (n)
        begin
            sel = $urandom_range(0, 29);
            if (sel == 0)
                push_byte(BYTE_START);
            else if (sel == 1)
            begin
                push_byte(BYTE_ESC);
                push_byte(BYTE_W'($urandom_range(0, 255)));
            end
            else if (sel == 2)
                push_payload(BYTE_ESC + BYTE_W'($urandom_range(0, 2)));
            else
                push_payload(BYTE_W'($urandom_range(0, 255)));
        end
        sel = $urandom_range(0, 19);
        if (sel < 17)
            push_byte(BYTE_END);
        else if (sel == 17)
            push_byte(BYTE_ESC);  // dangling escape swallows the next start
    endtask

    // Fills the payload to the limit, then ends the frame or pushes one byte too many.
    task automatic long_frame(input bit overflow);
        push_byte(BYTE_START);
        repeat (eff_limit) push_payload(BYTE_W'($urandom_range(0, 255)));
        if (overflow)
            push_payload(BYTE_W'($urandom_range(0, 255)));
        else
            push_byte(BYTE_END);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_limit(input int v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(v);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        eff_limit = (v == 0) ? 1 : ((v > MAXP) ? MAXP : v);
    endtask

    // receiver: stall pattern picks a new random mode after each random span, one long hold-off on request
    initial
    begin
        int  mode;
        int  span;
        int  hold_left;
        bit  held;
        mode = 0;
        span = 0;
        hold_left = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(10, 80);
                end
                span--;
                unique case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    initial
    begin
        logic [BYTE_W-1:0] opening[] = '{
            8'h00, 8'hFF, BYTE_ESC, BYTE_END,
            BYTE_START, BYTE_END,
            BYTE_START, 8'h00, 8'hFF,
            BYTE_ESC, BYTE_START ^ ESC_XOR, BYTE_ESC, BYTE_ESC ^ ESC_XOR,
            BYTE_ESC, BYTE_END ^ ESC_XOR, BYTE_ESC, BYTE_ESC,
            BYTE_START, BYTE_START, 8'h41, BYTE_END
        };
        logic [BYTE_W-1:0] tight[] = '{
            BYTE_START, 8'h11, 8'h22, 8'h33,
            BYTE_START, BYTE_ESC, 8'h00, BYTE_ESC, 8'h01, BYTE_END
        };
        int limits[10] = '{1, 511, 3, 256, 2, 257, 255, 0, 0, 0};
        int phase_start;
        limits[7] = $urandom_range(4, 20);
        limits[8] = $urandom_range(21, 300);
        limits[9] = $urandom_range(0, 511);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            push_byte(opening[i]);
        drain();
        set_limit(0);  // acts as a limit of one
        foreach (tight[i])
            push_byte(tight[i]);

        foreach (limits[i])
        begin
            drain();
            set_limit(limits[i]);
            if (i == 1)
                hold_req <= 1'b1;
            if (limits[i] == 511)
                long_frame(1'b1);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_frame();
        end

        drain();
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #6ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
